/* design/rrts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared constants for the round-robin thread scheduler: thread states,
// request codes, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package rrts_pkg;

  localparam int MAX_THREADS_DEF   = 16;
  localparam int SLEEP_BITS_DEF    = 16;
  localparam int CPU_TIME_BITS_DEF = 32;

  localparam logic [2:0] ST_EMPTY    = 3'd0;
  localparam logic [2:0] ST_NEW      = 3'd1;
  localparam logic [2:0] ST_READY    = 3'd2;
  localparam logic [2:0] ST_RUNNING  = 3'd3;
  localparam logic [2:0] ST_SLEEPING = 3'd4;

  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_CREATE  = 3'd1;
  localparam logic [2:0] REQ_READY   = 3'd2;
  localparam logic [2:0] REQ_SLEEP   = 3'd3;
  localparam logic [2:0] REQ_AWAKEN  = 3'd4;
  localparam logic [2:0] REQ_RELINQ  = 3'd5;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_FULL    = 2'd1;
  localparam logic [1:0] STS_UNKNOWN = 2'd2;

endpackage
`default_nettype wire

/* design/round_robin_thread_scheduler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// Thread table with round-robin selection and per-thread sleep timers.
// ----------------------------------------------------------------------------
// One request is taken at a time. Create, make ready, awaken, a tick with
// locks held and unused codes need no scheduling pass. A tick, sleep or
// relinquish runs a scheduling pass over the thread table, which sits in a
// memory with one read port and one write port: one entry read and one
// written back per cycle. A finished result is held in the output register
// while the next request is accepted; a result still waiting there when the
// next one is ready holds the block until it is taken. Slots past the thread
// count read as empty, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler #(
  parameter int MAX_THREADS   = rrts_pkg::MAX_THREADS_DEF,
  parameter int SLEEP_BITS    = rrts_pkg::SLEEP_BITS_DEF,
  parameter int CPU_TIME_BITS = rrts_pkg::CPU_TIME_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // thread_id[3:0], sleep_ticks[19:4], sleep_forever[20], locks_held[21]
  input  wire logic [23:0] in_tdata,
  // req_type[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // running_thread[3:0], switched[4], switch_pending[5], status[7:6],
  // new_thread_id[11:8], running_cpu_time[43:12]
  output logic [47:0]      out_tdata
);
  import rrts_pkg::*;

  localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_THREADS);
  localparam logic [IW-1:0] LAST = IW'(MAX_THREADS - 1);

  typedef struct packed {
    logic [2:0]               st;
    logic                     fv;
    logic [SLEEP_BITS-1:0]    sl;
    logic [CPU_TIME_BITS-1:0] cpu;
  } ent_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_MOD, S_SWEEP, S_FIXA, S_FIXB, S_PUSH
  } state_t;

  ent_t mem [MAX_THREADS];
  ent_t rd_q;
  logic [IW-1:0] rd_a_r;

  state_t state_r;
  logic [2:0]  req_r;
  logic [3:0]  tid_r;
  logic [15:0] ticks_r;
  logic        fv_r, locks_r;
  logic [CW-1:0] total_r, rc_r;
  logic [IW-1:0] cur_r, addr_r, cand_r, new_id_r;
  logic        pend_r, v0_r, p_vld_r, found_r, sw_r;
  logic [1:0]  status_r;
  logic [CPU_TIME_BITS-1:0] cur_cpu_r;
  ent_t        cand_ent_r, cur_ent_r;

  logic          rd_en, we;
  logic [IW-1:0] rd_a, wa;
  ent_t          wd, rd_fix, upd;
  logic [CW+3:0] tid_big;
  logic [IW-1:0] tid_a;
  logic          tid_ok;
  logic [SLEEP_BITS+15:0] tk_big;
  logic [SLEEP_BITS-1:0]  tk;
  logic [SLEEP_BITS-1:0]  sl_dec;
  logic [IW+3:0]          cur_big, new_big;
  logic [CPU_TIME_BITS+31:0] cpu_big;

  assign tid_big = {{CW{1'b0}}, tid_r};
  assign tid_a   = tid_big[IW-1:0];
  assign tid_ok  = tid_big < {4'b0, total_r};
  assign tk_big  = {{SLEEP_BITS{1'b0}}, ticks_r};
  assign tk      = (tk_big[SLEEP_BITS-1:0] == '0) ? SLEEP_BITS'(1) : tk_big[SLEEP_BITS-1:0];
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    rd_fix = rd_q;
    if ({1'b0, rd_a_r} >= total_r) begin
      rd_fix.st = ST_EMPTY;
    end else if (rd_a_r == '0 && !v0_r) begin
      rd_fix.st  = ST_RUNNING;
      rd_fix.fv  = 1'b0;
      rd_fix.cpu = '0;
    end
    sl_dec = rd_fix.sl - SLEEP_BITS'(1);
    upd = rd_fix;
    if (rd_fix.st == ST_SLEEPING) begin
      if (!rd_fix.fv) begin
        upd.sl = sl_dec;
        if (sl_dec == '0) upd.st = ST_READY;
      end
    end else if (rd_fix.st == ST_RUNNING) begin
      upd.cpu = rd_fix.cpu + CPU_TIME_BITS'(1);
    end
  end

  always_comb begin
    rd_en = 1'b0;
    rd_a  = '0;
    we    = 1'b0;
    wa    = '0;
    wd    = rd_fix;
    unique case (state_r)
      S_EXEC: begin
        if (req_r == REQ_CREATE) begin
          we = total_r < MAXC;
          wa = total_r[IW-1:0];
          wd = '{st: ST_NEW, fv: 1'b0, sl: '0, cpu: '0};
        end else if ((req_r == REQ_READY || req_r == REQ_AWAKEN) && tid_ok) begin
          rd_en = 1'b1;
          rd_a  = tid_a;
        end else if (req_r == REQ_SLEEP) begin
          rd_en = 1'b1;
          rd_a  = cur_r;
        end
      end
      S_MOD: begin
        wa = rd_a_r;
        if (req_r == REQ_SLEEP) begin
          we    = 1'b1;
          wd.st = ST_SLEEPING;
          wd.fv = fv_r;
          wd.sl = tk;
        end else if (req_r == REQ_READY) begin
          we    = 1'b1;
          wd.st = ST_READY;
        end else begin
          we    = rd_fix.st == ST_SLEEPING;
          wd.st = ST_READY;
        end
      end
      S_SWEEP: begin
        rd_en = rc_r != MAXC;
        rd_a  = addr_r;
        we    = p_vld_r;
        wa    = rd_a_r;
        wd    = upd;
      end
      S_FIXA: begin
        we    = found_r;
        wa    = cand_r;
        wd    = cand_ent_r;
        wd.st = ST_RUNNING;
      end
      S_FIXB: begin
        we    = found_r && cur_ent_r.st == ST_RUNNING;
        wa    = cur_r;
        wd    = cur_ent_r;
        wd.st = ST_READY;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q   <= mem[rd_a];
      rd_a_r <= rd_a;
    end
  end

  assign cur_big = {4'b0, cur_r};
  assign new_big = {4'b0, new_id_r};
  assign cpu_big = {32'b0, cur_cpu_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      total_r    <= CW'(1);
      cur_r      <= '0;
      pend_r     <= 1'b0;
      v0_r       <= 1'b0;
      cur_cpu_r  <= '0;
      p_vld_r    <= 1'b0;
      found_r    <= 1'b0;
      rc_r       <= '0;
      out_tvalid <= 1'b0;
    end else begin
      if (we && wa == '0) v0_r <= 1'b1;
      if (out_tvalid && out_tready && state_r != S_PUSH) out_tvalid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            req_r    <= in_tuser;
            tid_r    <= in_tdata[3:0];
            ticks_r  <= in_tdata[19:4];
            fv_r     <= in_tdata[20];
            locks_r  <= in_tdata[21];
            status_r <= STS_OK;
            new_id_r <= '0;
            sw_r     <= 1'b0;
            state_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          rc_r    <= '0;
          addr_r  <= (cur_r == LAST) ? '0 : cur_r + IW'(1);
          found_r <= 1'b0;
          p_vld_r <= 1'b0;
          unique case (req_r)
            REQ_TICK: begin
              if (locks_r) begin
                pend_r  <= 1'b1;
                state_r <= S_PUSH;
              end else begin
                pend_r  <= 1'b0;
                state_r <= S_SWEEP;
              end
            end
            REQ_CREATE: begin
              state_r <= S_PUSH;
              if (total_r < MAXC) begin
                new_id_r <= total_r[IW-1:0];
                total_r  <= total_r + CW'(1);
              end else begin
                status_r <= STS_FULL;
              end
            end
            REQ_READY, REQ_AWAKEN: begin
              if (tid_ok) begin
                state_r <= S_MOD;
              end else begin
                status_r <= STS_UNKNOWN;
                state_r  <= S_PUSH;
              end
            end
            REQ_SLEEP: state_r <= S_MOD;
            REQ_RELINQ: begin
              pend_r  <= 1'b0;
              state_r <= S_SWEEP;
            end
            default: state_r <= S_PUSH;
          endcase
        end
        S_MOD: begin
          if (req_r == REQ_SLEEP) begin
            pend_r  <= 1'b0;
            state_r <= S_SWEEP;
          end else begin
            state_r <= S_PUSH;
          end
        end
        S_SWEEP: begin
          p_vld_r <= rd_en;
          if (rd_en) begin
            rc_r   <= rc_r + CW'(1);
            addr_r <= (addr_r == LAST) ? '0 : addr_r + IW'(1);
          end
          if (p_vld_r) begin
            if (upd.st == ST_READY && !found_r && rd_a_r != cur_r) begin
              found_r    <= 1'b1;
              cand_r     <= rd_a_r;
              cand_ent_r <= upd;
            end
            if (rd_a_r == cur_r) cur_ent_r <= upd;
          end
          if (!rd_en && !p_vld_r) state_r <= S_FIXA;
        end
        S_FIXA: state_r <= S_FIXB;
        S_FIXB: begin
          if (found_r) begin
            cur_r     <= cand_r;
            cur_cpu_r <= cand_ent_r.cpu;
            sw_r      <= 1'b1;
          end else begin
            cur_cpu_r <= cur_ent_r.cpu;
          end
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (!out_tvalid || out_tready) begin
            out_tvalid <= 1'b1;
            out_tdata  <= {4'b0, cpu_big[31:0], new_big[3:0], status_r, pend_r, sw_r,
                           cur_big[3:0]};
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the round-robin thread scheduler. A directed table
// covers reset, creation, full table, unknown slots, sleeps, wakes and ticks
// under locks; random request streams follow. Every result is compared with
// a behavioural thread table kept in step with accepted requests.
// ----------------------------------------------------------------------------
module tb_top;
  import rrts_pkg::*;

  localparam int NSLOT = 16;

  typedef struct packed {
    logic [31:0] cpu;
    logic [3:0]  new_id;
    logic [1:0]  sts;
    logic        pend;
    logic        sw;
    logic [3:0]  run;
  } sched_res_t;

  typedef struct {
    logic [2:0]  req;
    logic [3:0]  tid;
    logic [15:0] ticks;
    logic        forever_f;
    logic        locks;
    logic        chk;
    sched_res_t  res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  round_robin_thread_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [2:0]  thr_st [NSLOT];
  logic [15:0] thr_sleep [NSLOT];
  logic        thr_fvr [NSLOT];
  logic [31:0] thr_cpu [NSLOT];
  int          thr_count;
  logic [3:0]  cur_slot;
  logic        pend_sw;

  sched_res_t  expected_q [$];
  int          n_errors = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_off = 0;

  function automatic logic sched_pass();
    logic [3:0] cand;
    pend_sw = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      if (thr_st[i] == ST_SLEEPING) begin
        if (!thr_fvr[i]) begin
          thr_sleep[i] = thr_sleep[i] - 16'd1;
          if (thr_sleep[i] == 16'd0) thr_st[i] = ST_READY;
        end
      end else if (thr_st[i] == ST_RUNNING) begin
        thr_cpu[i] = thr_cpu[i] + 32'd1;
      end
    end
    for (int k = 1; k < NSLOT; k++) begin
      cand = cur_slot + 4'(k);
      if (thr_st[cand] == ST_READY) begin
        if (thr_st[cur_slot] == ST_RUNNING) thr_st[cur_slot] = ST_READY;
        thr_st[cand] = ST_RUNNING;
        cur_slot = cand;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic sched_res_t predict_request(logic [2:0] req, logic [3:0] tid,
                                                 logic [15:0] ticks, logic fv,
                                                 logic locks);
    sched_res_t r;
    r = '0;
    case (req)
      REQ_TICK: begin
        if (locks) pend_sw = 1'b1;
        else r.sw = sched_pass();
      end
      REQ_CREATE: begin
        if (thr_count >= NSLOT) r.sts = STS_FULL;
        else begin
          thr_st[thr_count] = ST_NEW;
          thr_cpu[thr_count] = '0;
          thr_fvr[thr_count] = 1'b0;
          r.new_id = 4'(thr_count);
          thr_count++;
        end
      end
      REQ_READY: begin
        if (tid >= thr_count) r.sts = STS_UNKNOWN;
        else thr_st[tid] = ST_READY;
      end
      REQ_SLEEP: begin
        thr_sleep[cur_slot] = (ticks == 16'd0) ? 16'd1 : ticks;
        thr_fvr[cur_slot] = fv;
        thr_st[cur_slot] = ST_SLEEPING;
        r.sw = sched_pass();
      end
      REQ_AWAKEN: begin
        if (tid >= thr_count) r.sts = STS_UNKNOWN;
        else if (thr_st[tid] == ST_SLEEPING) thr_st[tid] = ST_READY;
      end
      REQ_RELINQ: r.sw = sched_pass();
      default: ;
    endcase
    r.run = cur_slot;
    r.pend = pend_sw;
    r.cpu = thr_cpu[cur_slot];
    return r;
  endfunction

  task automatic send_request(stim_row_t s);
    sched_res_t r;
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= s.req;
    in_tdata <= {2'b00, s.locks, s.forever_f, s.ticks, s.tid};
    do @(posedge clk); while (!in_tready);
    r = predict_request(s.req, s.tid, s.ticks, s.forever_f, s.locks);
    if (s.chk && r != s.res) begin
      $error("table row disagrees with predictor: exp %h got %h", s.res, r);
      n_errors++;
    end
    expected_q.push_back(r);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: %h", out_tdata);
          n_errors++;
        end else begin
          sched_res_t e, a;
          e = expected_q.pop_front();
          a = sched_res_t'(out_tdata[43:0]);
          if (a.run !== e.run) begin
            $error("running_thread exp %0d got %0d", e.run, a.run); n_errors++;
          end
          if (a.sw !== e.sw) begin
            $error("switched exp %0d got %0d", e.sw, a.sw); n_errors++;
          end
          if (a.pend !== e.pend) begin
            $error("switch_pending exp %0d got %0d", e.pend, a.pend); n_errors++;
          end
          if (a.sts !== e.sts) begin
            $error("status exp %0d got %0d", e.sts, a.sts); n_errors++;
          end
          if (a.new_id !== e.new_id) begin
            $error("new_thread_id exp %0d got %0d", e.new_id, a.new_id); n_errors++;
          end
          if (a.cpu !== e.cpu) begin
            $error("running_cpu_time exp %0d got %0d", e.cpu, a.cpu); n_errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic stim_row_t mk(logic [2:0] req, logic [3:0] tid, logic [15:0] ticks,
                                   logic fv, logic locks);
    stim_row_t s;
    s.req = req; s.tid = tid; s.ticks = ticks; s.forever_f = fv; s.locks = locks;
    s.chk = 1'b0; s.res = '0;
    return s;
  endfunction

  function automatic stim_row_t mkx(logic [2:0] req, logic [3:0] tid, logic [15:0] ticks,
                                    logic fv, logic locks, sched_res_t res);
    stim_row_t s;
    s = mk(req, tid, ticks, fv, locks);
    s.chk = 1'b1; s.res = res;
    return s;
  endfunction

  function automatic stim_row_t rand_row(int phase_mix);
    stim_row_t s;
    int pick;
    logic [2:0] req;
    pick = $urandom_range(99);
    if (pick < 25) req = REQ_TICK;
    else if (pick < 30) req = REQ_CREATE;
    else if (pick < 50) req = REQ_READY;
    else if (pick < 62) req = REQ_SLEEP;
    else if (pick < 80) req = REQ_AWAKEN;
    else if (pick < 95) req = REQ_RELINQ;
    else req = 3'($urandom_range(6, 7));
    s = mk(req, 4'($urandom_range(15)),
           ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6)),
           ($urandom_range(3) == 0), ($urandom_range(3) == 0));
    if (phase_mix == 0 && req == REQ_SLEEP) s.ticks = 16'($urandom_range(3));
    return s;
  endfunction

  initial begin
    stim_row_t dir [$];
    for (int i = 0; i < NSLOT; i++) begin
      thr_st[i] = ST_EMPTY; thr_sleep[i] = '0; thr_fvr[i] = 1'b0; thr_cpu[i] = '0;
    end
    thr_st[0] = ST_RUNNING;
    thr_count = 1; cur_slot = '0; pend_sw = 1'b0;

    dir.push_back(mkx(REQ_TICK, 4'd0, 16'd0, 1'b0, 1'b1, '{32'd0, 4'd0, STS_OK, 1'b1, 1'b0, 4'd0}));
    dir.push_back(mkx(REQ_TICK, 4'd0, 16'd0, 1'b0, 1'b0, '{32'd1, 4'd0, STS_OK, 1'b0, 1'b0, 4'd0}));
    dir.push_back(mkx(REQ_READY, 4'd15, 16'd0, 1'b0, 1'b0, '{32'd1, 4'd0, STS_UNKNOWN, 1'b0, 1'b0, 4'd0}));
    dir.push_back(mkx(REQ_AWAKEN, 4'd1, 16'hffff, 1'b1, 1'b1, '{32'd1, 4'd0, STS_UNKNOWN, 1'b0, 1'b0, 4'd0}));
    dir.push_back(mkx(REQ_CREATE, 4'd0, 16'd0, 1'b0, 1'b0, '{32'd1, 4'd1, STS_OK, 1'b0, 1'b0, 4'd0}));
    dir.push_back(mk(REQ_READY, 4'd1, 16'd0, 1'b0, 1'b0));
    dir.push_back(mk(REQ_SLEEP, 4'd0, 16'd0, 1'b0, 1'b1));
    dir.push_back(mk(REQ_SLEEP, 4'd0, 16'd1, 1'b0, 1'b0));
    dir.push_back(mk(REQ_SLEEP, 4'd0, 16'hffff, 1'b1, 1'b0));
    dir.push_back(mk(REQ_AWAKEN, 4'd1, 16'd0, 1'b0, 1'b0));
    dir.push_back(mk(REQ_AWAKEN, 4'd0, 16'd0, 1'b0, 1'b0));
    dir.push_back(mk(REQ_READY, 4'd0, 16'd0, 1'b0, 1'b0));
    dir.push_back(mk(REQ_RELINQ, 4'd0, 16'd0, 1'b0, 1'b1));
    dir.push_back(mk(3'd6, 4'd15, 16'hffff, 1'b1, 1'b1));
    dir.push_back(mk(3'd7, 4'd0, 16'd0, 1'b0, 1'b0));
    for (int i = 0; i < 14; i++) dir.push_back(mk(REQ_CREATE, 4'd0, 16'd0, 1'b0, 1'b0));
    dir.push_back(mk(REQ_CREATE, 4'd0, 16'd0, 1'b0, 1'b0));
    dir.push_back(mk(REQ_READY, 4'd15, 16'd0, 1'b0, 1'b0));
    dir.push_back(mk(REQ_RELINQ, 4'd0, 16'd0, 1'b0, 1'b0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir[i]) send_request(dir[i]);
    dir[$].chk = 1'b0;
    drain_results();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 66; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 66; end
        3: begin idle_pct = 15; stall_pct = 15; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      for (int n = 0; n < 230; n++) begin
        if (ph == 4 && n == 20) hold_off = 300;
        if (n == 100) drain_results();
        send_request(rand_row(ph));
      end
    end

    drain_results();
    repeat (60) @(posedge clk);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
